FILE: sv/lcdws_pkg.sv
`timescale 1ns / 1ps

package lcdws_pkg;

	// request modes
	localparam logic [2:0] MODE_CMD    = 3'd0;
	localparam logic [2:0] MODE_DATA   = 3'd1;
	localparam logic [2:0] MODE_INIT   = 3'd2;
	localparam logic [2:0] MODE_CURSOR = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic REG_PULSE_DELAY = 1'b0;
	localparam logic REG_INIT_DELAY  = 1'b1;

	localparam logic [15:0] PULSE_DELAY_RST = 16'd1600;
	localparam logic [23:0] INIT_DELAY_RST  = 24'd800000;

	// controller command bytes
	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] NIB_4BIT     = 8'h02;
	localparam logic [7:0] HI_NIB_MASK  = 8'hF0;
	localparam logic [7:0] LO_NIB_MASK  = 8'h0F;

	// init expansion steps
	localparam logic [2:0] INIT_WAIT  = 3'd0;
	localparam logic [2:0] INIT_NIB   = 3'd1;
	localparam logic [2:0] INIT_FUNC  = 3'd2;
	localparam logic [2:0] INIT_DISP  = 3'd3;

	// phase numbers within one nibble
	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_NIBBLE,
		OP_WAIT
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       rs;
		logic [7:0] data;
		logic       last;
	} op_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QLVL_W-1:0] level;
	} q_stat_t;

	typedef enum logic {
		FE_IDLE,
		FE_EXPAND
	} fe_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

FILE: sv/lcdws_front.sv
`timescale 1ns / 1ps

module lcdws_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       mode,
	input  logic [7:0]       value,
	input  logic             row,
	input  logic [5:0]       col,
	output logic             push,
	output lcdws_pkg::op_t   push_op,
	input  lcdws_pkg::q_stat_t q_stat
);

	lcdws_pkg::fe_state_t state_q, state_d;
	logic [2:0] mode_q;
	logic [7:0] value_q;
	logic       row_q;
	logic [5:0] col_q;
	logic [2:0] step_q, step_d;
	logic       accept;

	assign in_stall = (state_q != lcdws_pkg::FE_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdws_pkg::FE_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			value_q <= value;
			row_q   <= row;
			col_q   <= col;
		end
	end

	// classify the held request into its next queue operation
	always_comb begin
		push_op.kind = lcdws_pkg::OP_BYTE;
		push_op.rs   = 1'b0;
		push_op.data = value_q;
		push_op.last = 1'b1;
		case (mode_q)
			lcdws_pkg::MODE_DATA: begin
				push_op.rs = 1'b1;
			end
			lcdws_pkg::MODE_INIT: begin
				push_op.last = 1'b0;
				case (step_q)
					lcdws_pkg::INIT_WAIT: begin
						push_op.kind = lcdws_pkg::OP_WAIT;
						push_op.data = '0;
					end
					lcdws_pkg::INIT_NIB: begin
						push_op.kind = lcdws_pkg::OP_NIBBLE;
						push_op.data = lcdws_pkg::NIB_4BIT;
					end
					lcdws_pkg::INIT_FUNC: push_op.data = lcdws_pkg::CMD_FUNC_SET;
					lcdws_pkg::INIT_DISP: push_op.data = lcdws_pkg::CMD_DISP_ON;
					default: begin
						push_op.data = lcdws_pkg::CMD_ENTRY;
						push_op.last = 1'b1;
					end
				endcase
			end
			lcdws_pkg::MODE_CURSOR: begin
				push_op.data = {1'b1, row_q, col_q};
			end
			lcdws_pkg::MODE_CLEAR: begin
				if (step_q == '0) begin
					push_op.data = lcdws_pkg::CMD_CLEAR;
					push_op.last = 1'b0;
				end else begin
					push_op.data = lcdws_pkg::CMD_HOME;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		push    = 1'b0;
		case (state_q)
			lcdws_pkg::FE_IDLE: begin
				if (accept) begin
					state_d = lcdws_pkg::FE_EXPAND;
					step_d  = '0;
				end
			end
			lcdws_pkg::FE_EXPAND: begin
				if (!q_stat.full) begin
					push = 1'b1;
					if (push_op.last) begin
						state_d = lcdws_pkg::FE_IDLE;
					end else begin
						step_d = step_q + 3'd1;
					end
				end
			end
			default: state_d = lcdws_pkg::FE_IDLE;
		endcase
	end

endmodule

FILE: sv/lcdws_queue.sv
`timescale 1ns / 1ps

module lcdws_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lcdws_pkg::op_t     push_op,
	input  logic               pop,
	output lcdws_pkg::op_t     head_op,
	output lcdws_pkg::q_stat_t q_stat
);

	lcdws_pkg::op_t mem_q [lcdws_pkg::QDEPTH];
	logic [lcdws_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lcdws_pkg::QLVL_W-1:0] level_q;
	logic do_push, do_pop;

	assign q_stat.level = level_q;
	assign q_stat.full  = (level_q == lcdws_pkg::QLVL_W'(lcdws_pkg::QDEPTH));
	assign q_stat.empty = (level_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_op      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_op;
	end

endmodule

FILE: sv/lcdws_back.sv
`timescale 1ns / 1ps

module lcdws_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lcdws_pkg::op_t     head_op,
	input  lcdws_pkg::q_stat_t q_stat,
	output logic               pop,
	input  logic [15:0]        pulse_delay,
	input  logic [23:0]        init_delay,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               reg_select,
	output logic               enable,
	output logic [3:0]         nibble,
	output logic [23:0]        hold_cycles,
	output logic               last
);

	lcdws_pkg::bk_state_t state_q, state_d;
	lcdws_pkg::op_t op_q, op_d;
	logic       nib_q, nib_d;
	logic [1:0] ph_q, ph_d;
	logic       out_valid_q;
	logic       emit, done, load;
	logic       ph_en;
	logic [3:0] ph_nib;
	logic [23:0] ph_hold;
	logic [7:0] hi_bits, lo_bits;

	assign load    = !out_valid_q || !out_stall;
	assign hi_bits = op_q.data & lcdws_pkg::HI_NIB_MASK;
	assign lo_bits = op_q.data & lcdws_pkg::LO_NIB_MASK;

	// levels of the current phase
	always_comb begin
		ph_en   = (ph_q == lcdws_pkg::PH_HIGH);
		ph_hold = (pulse_delay == '0) ? 24'd1 : {8'd0, pulse_delay};
		case (op_q.kind)
			lcdws_pkg::OP_WAIT: begin
				ph_en   = 1'b1;
				ph_nib  = '0;
				ph_hold = (init_delay == '0) ? 24'd1 : init_delay;
				done    = 1'b1;
			end
			lcdws_pkg::OP_NIBBLE: begin
				ph_nib = lo_bits[3:0];
				done   = (ph_q == lcdws_pkg::PH_POST);
			end
			default: begin
				ph_nib = nib_q ? lo_bits[3:0] : hi_bits[7:4];
				done   = (ph_q == lcdws_pkg::PH_POST) && nib_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcdws_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		nib_q <= nib_d;
		ph_q  <= ph_d;
		if (emit) begin
			reg_select  <= op_q.rs;
			enable      <= ph_en;
			nibble      <= ph_nib;
			hold_cycles <= ph_hold;
			last        <= op_q.last && done;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		nib_d   = nib_q;
		ph_d    = ph_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			lcdws_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					op_d    = head_op;
					nib_d   = 1'b0;
					ph_d    = lcdws_pkg::PH_PRE;
					state_d = lcdws_pkg::BK_RUN;
				end
			end
			lcdws_pkg::BK_RUN: begin
				if (load) begin
					emit = 1'b1;
					if (done) begin
						state_d = lcdws_pkg::BK_IDLE;
					end else if (ph_q == lcdws_pkg::PH_POST) begin
						nib_d = 1'b1;
						ph_d  = lcdws_pkg::PH_PRE;
					end else begin
						ph_d = ph_q + 2'd1;
					end
				end
			end
			default: state_d = lcdws_pkg::BK_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/lcd_4bit_write_sequencer_top.sv
`timescale 1ns / 1ps

// Character LCD write sequencer for a 4-bit bus. Each request (command byte,
// data byte, init, set cursor, clear) is turned into a run of pin phases
// (RS, EN, D7..D4 and a hold count); the downstream pin driver holds each
// phase for hold_cycles. A request is expanded by the front end into one to
// five queued operations, one per cycle while the queue has room, and the
// next request is taken once the last of them is pushed. The back end loads
// an operation in its idle state and then emits one phase per cycle while the
// output is not stalled: both nibbles of a byte, the init nibble alone, or the
// single phase of the power-up wait. The phase counter in the back end sets
// the pace; a 4-entry queue lets the front end run ahead of a stalled output.
// Configuration writes are taken at once (cfg_ready is always high); index 0
// is pulse_delay, index 1 is init_delay, and a delay of zero is held as one.
module lcd_4bit_write_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  value,
	input  logic        row,
	input  logic [5:0]  col,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic        enable,
	output logic [3:0]  nibble,
	output logic [23:0] hold_cycles,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	logic [15:0] pulse_delay_q;
	logic [23:0] init_delay_q;
	logic        push, pop;
	lcdws_pkg::op_t     push_op, head_op;
	lcdws_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_delay_q <= lcdws_pkg::PULSE_DELAY_RST;
			init_delay_q  <= lcdws_pkg::INIT_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcdws_pkg::REG_PULSE_DELAY: pulse_delay_q <= cfg_data[15:0];
				lcdws_pkg::REG_INIT_DELAY:  init_delay_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lcdws_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.row      (row),
		.col      (col),
		.push     (push),
		.push_op  (push_op),
		.q_stat   (q_stat)
	);

	lcdws_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.q_stat  (q_stat)
	);

	lcdws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_op     (head_op),
		.q_stat      (q_stat),
		.pop         (pop),
		.pulse_delay (pulse_delay_q),
		.init_delay  (init_delay_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reg_select  (reg_select),
		.enable      (enable),
		.nibble      (nibble),
		.hold_cycles (hold_cycles),
		.last        (last)
	);

	// queue never overfills
	a_q_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= lcdws_pkg::QLVL_W'(lcdws_pkg::QDEPTH))
		else $error("queue level beyond depth");

	// front end only pushes when there is room
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	// a phase never has a zero hold count
	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hold_cycles != '0)
		else $error("zero hold count");

	// every request ends with enable low
	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> !enable)
		else $error("request ends with enable high");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// address-set command and second-row offset for the cursor request
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;
	// mode codes with no meaning of their own, sent as command bytes
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

	localparam int RAND_PER_PHASE = 20;
	localparam int DRAIN_CYCLES   = 12;
	localparam int QUIET_LIMIT    = 5000;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] value;
		logic       row;
		logic [5:0] col;
	} lcd_req_t;

	typedef struct packed {
		logic        reg_select;
		logic        enable;
		logic [3:0]  nibble;
		logic [23:0] hold_cycles;
		logic        last;
	} pin_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [7:0]  value = '0;
	logic        row = 1'b0;
	logic [5:0]  col = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_select;
	logic        enable;
	logic [3:0]  nibble;
	logic [23:0] hold_cycles;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [23:0] cfg_data = '0;

	lcd_req_t   requests_due[$];
	pin_phase_t phases_due[$];

	logic [15:0] pulse_setting = lcdws_pkg::PULSE_DELAY_RST;
	logic [23:0] init_setting  = lcdws_pkg::INIT_DELAY_RST;

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int errors          = 0;
	int requests_sent   = 0;
	int phases_checked  = 0;
	int reg_writes      = 0;
	int quiet_cycles    = 0;

	lcd_4bit_write_sequencer_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.value       (value),
		.row         (row),
		.col         (col),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reg_select  (reg_select),
		.enable      (enable),
		.nibble      (nibble),
		.hold_cycles (hold_cycles),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pin phase expansion of one request
	function automatic void push_phase(logic rs, logic en, logic [3:0] nib,
		logic [23:0] hold);
		pin_phase_t ph;
		ph.reg_select  = rs;
		ph.enable      = en;
		ph.nibble      = nib;
		ph.hold_cycles = hold;
		ph.last        = 1'b0;
		phases_due.push_back(ph);
	endfunction

	function automatic void push_nibble(logic rs, logic [3:0] nib);
		logic [23:0] hold;
		hold = (pulse_setting == 16'd0) ? 24'd1 : {8'd0, pulse_setting};
		push_phase(rs, 1'b0, nib, hold);
		push_phase(rs, 1'b1, nib, hold);
		push_phase(rs, 1'b0, nib, hold);
	endfunction

	function automatic void push_byte(logic rs, logic [7:0] b);
		logic [7:0] hi;
		hi = (b & lcdws_pkg::HI_NIB_MASK) >> 4;
		push_nibble(rs, hi[3:0]);
		push_nibble(rs, b[3:0] & lcdws_pkg::LO_NIB_MASK[3:0]);
	endfunction

	function automatic void expand_request(lcd_req_t req);
		pin_phase_t tail;
		case (req.mode)
			lcdws_pkg::MODE_DATA: begin
				push_byte(1'b1, req.value);
			end
			lcdws_pkg::MODE_INIT: begin
				push_phase(1'b0, 1'b1, 4'd0,
					(init_setting == 24'd0) ? 24'd1 : init_setting);
				push_nibble(1'b0, lcdws_pkg::NIB_4BIT[3:0]);
				push_byte(1'b0, lcdws_pkg::CMD_FUNC_SET);
				push_byte(1'b0, lcdws_pkg::CMD_DISP_ON);
				push_byte(1'b0, lcdws_pkg::CMD_ENTRY);
			end
			lcdws_pkg::MODE_CURSOR: begin
				push_byte(1'b0, CMD_SET_ADDR | (req.row ? ROW1_OFFSET : 8'd0)
					| {2'b00, req.col});
			end
			lcdws_pkg::MODE_CLEAR: begin
				push_byte(1'b0, lcdws_pkg::CMD_CLEAR);
				push_byte(1'b0, lcdws_pkg::CMD_HOME);
			end
			default: begin
				push_byte(1'b0, req.value);
			end
		endcase
		tail = phases_due.pop_back();
		tail.last = 1'b1;
		phases_due.push_back(tail);
	endfunction

	function automatic void queue_request(logic [2:0] m, logic [7:0] v, logic r, logic [5:0] c);
		lcd_req_t req;
		req.mode  = m;
		req.value = v;
		req.row   = r;
		req.col   = c;
		requests_due.push_back(req);
	endfunction

	function automatic void queue_random_requests(int count);
		int unsigned roll;
		logic [2:0]  m;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 30)
				m = lcdws_pkg::MODE_DATA;
			else if (roll < 50)
				m = lcdws_pkg::MODE_CMD;
			else if (roll < 68)
				m = lcdws_pkg::MODE_CURSOR;
			else if (roll < 80)
				m = lcdws_pkg::MODE_CLEAR;
			else if (roll < 90)
				m = lcdws_pkg::MODE_INIT;
			else
				m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			queue_request(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
				6'($urandom_range(63)));
		end
	endfunction

	// request driver
	always @(posedge clk) begin : drive_requests
		lcd_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				req.mode  = mode;
				req.value = value;
				req.row   = row;
				req.col   = col;
				expand_request(req);
				requests_sent++;
			end
			if (requests_due.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				req = requests_due.pop_front();
				in_valid <= 1'b1;
				mode     <= req.mode;
				value    <= req.value;
				row      <= req.row;
				col      <= req.col;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, logic [23:0] exp, logic [23:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
		end
	endfunction

	// phase monitor
	always @(posedge clk) begin : watch_phases
		pin_phase_t exp;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (phases_due.size() == 0) begin
					errors++;
					$display({"%0t: unexpected phase, expected none, ",
						"got rs %0b en %0b nib 0x%0h hold %0d last %0b"},
						$time, reg_select, enable, nibble, hold_cycles, last);
				end else begin
					exp = phases_due.pop_front();
					check_field("reg_select", 24'(exp.reg_select), 24'(reg_select));
					check_field("enable", 24'(exp.enable), 24'(enable));
					check_field("nibble", 24'(exp.nibble), 24'(nibble));
					check_field("hold_cycles", exp.hold_cycles, hold_cycles);
					check_field("last", 24'(exp.last), 24'(last));
					phases_checked++;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic idx, logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lcdws_pkg::REG_PULSE_DELAY)
			pulse_setting = data[15:0];
		else
			init_setting = data;
		reg_writes++;
	endtask

	task automatic drain;
		do
			@(posedge clk);
		while (requests_due.size() != 0 || in_valid || phases_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset delays, no idling, directed requests
		queue_request(lcdws_pkg::MODE_CMD, 8'h00, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_CMD, 8'hFF, 1'b1, 6'd63);
		queue_request(lcdws_pkg::MODE_DATA, 8'h00, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_DATA, 8'hFF, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_DATA, 8'hA5, 1'b1, 6'd63);
		queue_request(lcdws_pkg::MODE_DATA, 8'h5A, 1'b0, 6'd21);
		queue_request(lcdws_pkg::MODE_INIT, 8'h00, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_INIT, 8'hFF, 1'b1, 6'd63);
		queue_request(lcdws_pkg::MODE_CURSOR, 8'h00, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_CURSOR, 8'hFF, 1'b1, 6'd63);
		queue_request(lcdws_pkg::MODE_CURSOR, 8'h00, 1'b0, 6'd42);
		queue_request(lcdws_pkg::MODE_CURSOR, 8'h00, 1'b1, 6'd21);
		queue_request(lcdws_pkg::MODE_CLEAR, 8'h00, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_CLEAR, 8'hFF, 1'b1, 6'd63);
		queue_request(MODE_SPARE_LO, 8'hC3, 1'b0, 6'd0);
		queue_request(MODE_SPARE_MID, 8'h3C, 1'b1, 6'd63);
		queue_request(MODE_SPARE_HI, 8'h81, 1'b0, 6'd5);
		queue_request(lcdws_pkg::MODE_DATA, 8'h41, 1'b0, 6'd0);
		queue_request(lcdws_pkg::MODE_CMD, 8'h01, 1'b0, 6'd0);
		drain();

		// zero delays are held as one; sender idling
		write_reg(lcdws_pkg::REG_PULSE_DELAY, 24'd0);
		write_reg(lcdws_pkg::REG_INIT_DELAY, 24'd0);
		sender_idle_pct = 50;
		queue_random_requests(RAND_PER_PHASE);
		drain();

		// largest delays, upper data bits of the pulse register dropped; output stalls
		sender_idle_pct = 0;
		write_reg(lcdws_pkg::REG_PULSE_DELAY, 24'hFFFFFF);
		write_reg(lcdws_pkg::REG_INIT_DELAY, 24'hFFFFFF);
		stall_pct = 50;
		queue_random_requests(RAND_PER_PHASE);
		drain();

		// smallest non-zero delays; idling on both sides
		stall_pct = 0;
		write_reg(lcdws_pkg::REG_PULSE_DELAY, 24'd1);
		write_reg(lcdws_pkg::REG_INIT_DELAY, 24'd1);
		sender_idle_pct = 28;
		stall_pct       = 28;
		queue_random_requests(RAND_PER_PHASE);
		drain();

		// random delays at full rate
		sender_idle_pct = 0;
		stall_pct       = 0;
		write_reg(lcdws_pkg::REG_PULSE_DELAY, 24'($urandom_range(65535, 2)));
		write_reg(lcdws_pkg::REG_INIT_DELAY, 24'($urandom_range(24'hFFFFFF, 2)));
		queue_random_requests(RAND_PER_PHASE);
		drain();

		$display("covered %0d requests over five delay settings and four idling patterns",
			requests_sent);
		$display("checked %0d pin phases after %0d register writes, %0d errors",
			phases_checked, reg_writes, errors);
		if (errors == 0 && phases_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: lcd_4bit_write_sequencer_top.f
sv/lcdws_pkg.sv
sv/lcdws_front.sv
sv/lcdws_queue.sv
sv/lcdws_back.sv
sv/lcd_4bit_write_sequencer_top.sv
sim/tb_top.sv
